// ----- rtl/baee_pkg.sv -----
`default_nettype none

package baee_pkg;

   localparam int DEF_CAPACITY = 64;

   localparam int FUNC_W = 4;
   localparam int VAL_W  = 32;
   localparam int IDX_W  = 7;
   localparam int STAT_W = 3;
   localparam int POS_W  = 6;
   localparam int CNT_W  = 7;

   localparam logic [FUNC_W-1:0] FN_INS_FRONT = 4'd0;
   localparam logic [FUNC_W-1:0] FN_INS_END   = 4'd1;
   localparam logic [FUNC_W-1:0] FN_INS_AT    = 4'd2;
   localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 4'd3;
   localparam logic [FUNC_W-1:0] FN_DEL_END   = 4'd4;
   localparam logic [FUNC_W-1:0] FN_DEL_AT    = 4'd5;
   localparam logic [FUNC_W-1:0] FN_SEARCH    = 4'd6;
   localparam logic [FUNC_W-1:0] FN_ROTL      = 4'd7;
   localparam logic [FUNC_W-1:0] FN_ROTR      = 4'd8;
   localparam logic [FUNC_W-1:0] FN_REVERSE   = 4'd9;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0]       func;
      logic signed [VAL_W-1:0] value;
      logic [IDX_W-1:0]        index;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic [CNT_W-1:0]  count;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/bounded_array_edit_engine_core.sv -----
`default_nettype none
// channel   handshake                payload
// req       req_valid / req_ready    req_data  (func, value, index)
// rsp       rsp_valid / rsp_ready    rsp_data  (status, position, count)
//
// One request at a time; req_ready is high only while idle; one memory read a cycle.
// After accept, errors, no-ops and an empty search go to done; insert and delete shift
// the m elements behind the slot, then insert writes the value; search stops at the first
// hit; with n > 1 entries rotate moves the end element round, reverse swaps pairs.
// Reset clears the count and control; the element memory is not cleared.
// A held result in the rsp register does not block the next request; done waits for it.

module bounded_array_edit_engine_core #(
   parameter int CAPACITY = baee_pkg::DEF_CAPACITY
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire baee_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output baee_pkg::rsp_type      rsp_data
);
   import baee_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WALK,
      S_TAIL,
      S_GRAB,
      S_CATCH,
      S_SRCH,
      S_REV_RI,
      S_REV_RJ,
      S_REV_WI,
      S_REV_WJ,
      S_DONE
   } fsm_type;

   fsm_type          state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    left_ff, left_in;
   logic [AW-1:0]    rd_addr_ff, rd_addr_in;
   logic [AW-1:0]    wr_addr_ff, wr_addr_in;
   logic [AW-1:0]    tail_addr_ff, tail_addr_in;
   logic             down_ff, down_in;
   logic             tail_en_ff, tail_en_in;
   logic             issue_ff, issue_in;
   logic [VAL_W-1:0] hold_ff, hold_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [VAL_W-1:0] mem_wr_data;
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   logic [VAL_W-1:0] mem_rd_data;

   logic [CW-1:0]    cnt_m1;
   logic [XW-1:0]    idx_x;
   logic [XW-1:0]    cnt_x;
   logic             full;
   logic             empty;
   logic [AW-1:0]    ins_pos;
   logic [AW-1:0]    del_pos;

   assign cnt_m1 = count_ff - CW'(1);
   assign idx_x  = XW'(req_data.index);
   assign cnt_x  = XW'(count_ff);
   assign full   = (count_ff == CW'(CAPACITY));
   assign empty  = (count_ff == '0);

   always_comb begin
      case (req_data.func)
         FN_INS_FRONT: ins_pos = '0;
         FN_INS_END:   ins_pos = AW'(count_ff);
         default:      ins_pos = AW'(req_data.index);
      endcase
      case (req_data.func)
         FN_DEL_FRONT: del_pos = '0;
         FN_DEL_END:   del_pos = AW'(cnt_m1);
         default:      del_pos = AW'(req_data.index);
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      rd_addr_in   = rd_addr_ff;
      wr_addr_in   = wr_addr_ff;
      tail_addr_in = tail_addr_ff;
      down_in      = down_ff;
      tail_en_in   = tail_en_ff;
      issue_in     = issue_ff;
      hold_in      = hold_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = rd_addr_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_addr_ff;
      mem_wr_data  = mem_rd_data;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               issue_in        = 1'b0;
               tail_en_in      = 1'b0;
               down_in         = 1'b0;
               hold_in         = req_data.value;
               res_in.status   = ST_OK;
               res_in.position = '0;
               res_in.count    = CNT_W'(count_ff);
               state_in        = S_DONE;
               unique case (req_data.func) inside
                  FN_INS_FRONT, FN_INS_END, FN_INS_AT: begin
                     if (full) begin
                        res_in.status = ST_FULL;
                     end else if (req_data.func == FN_INS_AT && idx_x > cnt_x) begin
                        res_in.status = ST_BAD_INDEX;
                     end else begin
                        res_in.position = POS_W'(ins_pos);
                        res_in.count    = CNT_W'(count_ff + CW'(1));
                        count_in        = count_ff + CW'(1);
                        rd_addr_in      = AW'(cnt_m1);
                        wr_addr_in      = AW'(count_ff);
                        left_in         = count_ff - CW'(ins_pos);
                        down_in         = 1'b1;
                        tail_en_in      = 1'b1;
                        tail_addr_in    = ins_pos;
                        state_in        = S_WALK;
                     end
                  end
                  FN_DEL_FRONT, FN_DEL_END, FN_DEL_AT: begin
                     if (empty) begin
                        res_in.status = ST_EMPTY;
                     end else if (req_data.func == FN_DEL_AT && idx_x >= cnt_x) begin
                        res_in.status = ST_BAD_INDEX;
                     end else begin
                        res_in.position = POS_W'(del_pos);
                        res_in.count    = CNT_W'(cnt_m1);
                        count_in        = cnt_m1;
                        rd_addr_in      = del_pos + AW'(1);
                        wr_addr_in      = del_pos;
                        left_in         = cnt_m1 - CW'(del_pos);
                        state_in        = S_WALK;
                     end
                  end
                  FN_SEARCH: begin
                     res_in.status = ST_NOT_FOUND;
                     if (!empty) begin
                        rd_addr_in = '0;
                        wr_addr_in = '0;
                        left_in    = count_ff;
                        state_in   = S_SRCH;
                     end
                  end
                  FN_ROTL: begin
                     if (count_ff > CW'(1)) begin
                        rd_addr_in   = AW'(1);
                        wr_addr_in   = '0;
                        left_in      = cnt_m1;
                        tail_en_in   = 1'b1;
                        tail_addr_in = AW'(cnt_m1);
                        state_in     = S_GRAB;
                     end
                  end
                  FN_ROTR: begin
                     if (count_ff > CW'(1)) begin
                        rd_addr_in   = AW'(cnt_m1) - AW'(1);
                        wr_addr_in   = AW'(cnt_m1);
                        left_in      = cnt_m1;
                        down_in      = 1'b1;
                        tail_en_in   = 1'b1;
                        tail_addr_in = '0;
                        state_in     = S_GRAB;
                     end
                  end
                  FN_REVERSE: begin
                     if (count_ff > CW'(1)) begin
                        rd_addr_in = '0;
                        wr_addr_in = AW'(cnt_m1);
                        left_in    = count_ff >> 1;
                        state_in   = S_REV_RI;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            issue_in = (left_ff != '0);
            if (left_ff != '0) begin
               mem_rd_en  = 1'b1;
               rd_addr_in = down_ff ? rd_addr_ff - AW'(1) : rd_addr_ff + AW'(1);
               left_in    = left_ff - CW'(1);
            end
            if (issue_ff) begin
               mem_wr_en  = 1'b1;
               wr_addr_in = down_ff ? wr_addr_ff - AW'(1) : wr_addr_ff + AW'(1);
            end
            if (left_ff == '0 && !issue_ff) begin
               state_in = tail_en_ff ? S_TAIL : S_DONE;
            end
         end
         S_TAIL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = tail_addr_ff;
            mem_wr_data = hold_ff;
            state_in    = S_DONE;
         end
         S_GRAB: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = wr_addr_ff;
            state_in    = S_CATCH;
         end
         S_CATCH: begin
            hold_in  = mem_rd_data;
            state_in = S_WALK;
         end
         S_SRCH: begin
            issue_in = (left_ff != '0);
            if (left_ff != '0) begin
               mem_rd_en  = 1'b1;
               rd_addr_in = rd_addr_ff + AW'(1);
               left_in    = left_ff - CW'(1);
            end
            if (issue_ff) begin
               if (mem_rd_data == hold_ff) begin
                  res_in.status   = ST_OK;
                  res_in.position = POS_W'(wr_addr_ff);
                  issue_in        = 1'b0;
                  state_in        = S_DONE;
               end else begin
                  wr_addr_in = wr_addr_ff + AW'(1);
               end
            end else if (left_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_REV_RI: begin
            mem_rd_en = 1'b1;
            state_in  = S_REV_RJ;
         end
         S_REV_RJ: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = wr_addr_ff;
            hold_in     = mem_rd_data;
            state_in    = S_REV_WI;
         end
         S_REV_WI: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = rd_addr_ff;
            state_in    = S_REV_WJ;
         end
         S_REV_WJ: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = hold_ff;
            rd_addr_in  = rd_addr_ff + AW'(1);
            wr_addr_in  = wr_addr_ff - AW'(1);
            left_in     = left_ff - CW'(1);
            state_in    = (left_ff == CW'(1)) ? S_DONE : S_REV_RI;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      left_ff      <= left_in;
      rd_addr_ff   <= rd_addr_in;
      wr_addr_ff   <= wr_addr_in;
      tail_addr_ff <= tail_addr_in;
      down_ff      <= down_in;
      tail_en_ff   <= tail_en_in;
      hold_ff      <= hold_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   baee_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
      else $error("read and write of the same entry in one cycle");

   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("accepted word did not start work");

   a_issue: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> $past(mem_rd_en))
      else $error("write-back without a preceding read");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff)
      else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

// ----- rtl/baee_mem.sv -----
`default_nettype none

module baee_mem #(
   parameter int DEPTH = baee_pkg::DEF_CAPACITY,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [baee_pkg::VAL_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic [baee_pkg::VAL_W-1:0]      rd_data
);
   import baee_pkg::*;

   logic [VAL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- sim/baee_edit_checker.sv -----
`default_nettype none

module baee_edit_checker #(
   parameter int CAPACITY = baee_pkg::DEF_CAPACITY
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire baee_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire baee_pkg::rsp_type rsp_data,
   output int                     mismatch_count,
   output int                     replies_due
);
   import baee_pkg::*;

   logic [VAL_W-1:0] slots [CAPACITY];
   int unsigned      fill;
   rsp_type          expected_replies [$];

   function automatic rsp_type apply_edit(req_type w);
      rsp_type          r;
      int unsigned      p;
      logic [VAL_W-1:0] t;
      int               i;
      int               j;
      r.status = ST_OK;
      p = 0;
      case (w.func)
         FN_INS_FRONT, FN_INS_END, FN_INS_AT: begin
            if (fill >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (w.func == FN_INS_AT && w.index > fill) begin
               r.status = ST_BAD_INDEX;
            end else begin
               if (w.func == FN_INS_END) p = fill;
               else if (w.func == FN_INS_AT) p = w.index;
               for (i = fill; i > p; i--) slots[i] = slots[i-1];
               slots[p] = w.value;
               fill++;
            end
         end
         FN_DEL_FRONT, FN_DEL_END, FN_DEL_AT: begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
            end else if (w.func == FN_DEL_AT && w.index >= fill) begin
               r.status = ST_BAD_INDEX;
            end else begin
               if (w.func == FN_DEL_END) p = fill - 1;
               else if (w.func == FN_DEL_AT) p = w.index;
               for (i = p; i + 1 < fill; i++) slots[i] = slots[i+1];
               fill--;
            end
         end
         FN_SEARCH: begin
            r.status = ST_NOT_FOUND;
            for (i = 0; i < fill; i++) begin
               if (slots[i] == w.value) begin
                  r.status = ST_OK;
                  p = i;
                  break;
               end
            end
         end
         FN_ROTL: begin
            if (fill > 1) begin
               t = slots[0];
               for (i = 0; i + 1 < fill; i++) slots[i] = slots[i+1];
               slots[fill-1] = t;
            end
         end
         FN_ROTR: begin
            if (fill > 1) begin
               t = slots[fill-1];
               for (i = fill - 1; i > 0; i--) slots[i] = slots[i-1];
               slots[0] = t;
            end
         end
         FN_REVERSE: begin
            if (fill > 1) begin
               for (i = 0; 2 * i + 1 < fill; i++) begin
                  j = fill - 1 - i;
                  t = slots[i];
                  slots[i] = slots[j];
                  slots[j] = t;
               end
            end
         end
         default: ;
      endcase
      r.position = p[POS_W-1:0];
      r.count = fill[CNT_W-1:0];
      return r;
   endfunction

   initial begin
      mismatch_count = 0;
      replies_due = 0;
      fill = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fill = 0;
         expected_replies.delete();
      end else begin
         if (req_valid && req_ready) expected_replies.push_back(apply_edit(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected reply word: status %0d pos %0d count %0d",
                           rsp_data.status, rsp_data.position, rsp_data.count);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data.status !== want.status || rsp_data.position !== want.position ||
                   rsp_data.count !== want.count) begin
                  if (mismatch_count < 10)
                     $display("reply mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                              want.status, want.position, want.count,
                              rsp_data.status, rsp_data.position, rsp_data.count);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
      replies_due <= expected_replies.size();
   end

endmodule

`default_nettype wire

// ----- sim/bounded_array_edit_engine_core_tb.sv -----
`default_nettype none

module bounded_array_edit_engine_core_tb;
   import baee_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_WORDS = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int replies_due;
   int cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   bounded_array_edit_engine_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   baee_edit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .mismatch_count(mismatch_count), .replies_due(replies_due)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("** bounded_array_edit_engine_core: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   function automatic req_type edit_word(logic [FUNC_W-1:0] f, logic [VAL_W-1:0] v,
                                         logic [IDX_W-1:0] i);
      req_type w;
      w.func = f;
      w.value = v;
      w.index = i;
      return w;
   endfunction

   task automatic send_word(req_type w);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return $urandom;
      if (r == 3) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return 32'($signed($urandom_range(0, 7)) - 3);
   endfunction

   function automatic logic [IDX_W-1:0] pick_index();
      if ($urandom_range(0, 11) == 0) return IDX_W'($urandom_range(0, 127));
      return IDX_W'($urandom_range(0, 66));
   endfunction

   // fill-heavy, mixed, drain-heavy, mixed over each stretch of 200 words
   function automatic logic [FUNC_W-1:0] pick_func(int n);
      int slot;
      int r;
      slot = n % 200;
      r = $urandom_range(0, 99);
      if (slot < 90) begin
         if (r < 92) return FUNC_W'($urandom_range(FN_INS_FRONT, FN_INS_AT));
         return FUNC_W'($urandom_range(FN_DEL_FRONT, 15));
      end
      if (slot >= 120 && slot < 190) begin
         if (r < 88) return FUNC_W'($urandom_range(FN_DEL_FRONT, FN_DEL_AT));
         if (r < 94) return FUNC_W'($urandom_range(FN_INS_FRONT, FN_INS_AT));
         return FUNC_W'($urandom_range(FN_SEARCH, 15));
      end
      if (r < 10) return FUNC_W'($urandom_range(10, 15));
      return FUNC_W'($urandom_range(FN_INS_FRONT, FN_REVERSE));
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(edit_word(FN_SEARCH, 32'd0, 7'd0));
      send_word(edit_word(FN_DEL_FRONT, 32'd0, 7'd0));
      send_word(edit_word(FN_DEL_END, 32'd0, 7'd0));
      send_word(edit_word(FN_DEL_AT, 32'd0, 7'd0));
      send_word(edit_word(FN_ROTL, 32'd0, 7'd0));
      send_word(edit_word(FN_ROTR, 32'd0, 7'd0));
      send_word(edit_word(FN_REVERSE, 32'd0, 7'd0));
      send_word(edit_word(FN_INS_AT, 32'd9, 7'd1));
      send_word(edit_word(FN_INS_AT, 32'h8000_0000, 7'd0));
      send_word(edit_word(FN_ROTL, 32'd0, 7'd0));
      send_word(edit_word(FN_REVERSE, 32'd0, 7'd0));
      send_word(edit_word(FN_INS_END, 32'h7FFF_FFFF, 7'd0));
      send_word(edit_word(FN_INS_FRONT, 32'hFFFF_FFFF, 7'd0));
      send_word(edit_word(FN_INS_AT, 32'd3, 7'd127));
      send_word(edit_word(FN_INS_AT, 32'd5, 7'd2));
      send_word(edit_word(FN_SEARCH, 32'h7FFF_FFFF, 7'd0));
      send_word(edit_word(FN_SEARCH, 32'd7, 7'd0));
      send_word(edit_word(FN_ROTL, 32'd0, 7'd0));
      send_word(edit_word(FN_ROTR, 32'd0, 7'd0));
      send_word(edit_word(FN_REVERSE, 32'd0, 7'd0));
      send_word(edit_word(FN_DEL_AT, 32'd0, 7'd4));
      send_word(edit_word(FN_DEL_AT, 32'd0, 7'd127));
      send_word(edit_word(FN_DEL_AT, 32'd0, 7'd1));
      send_word(edit_word(4'd10, 32'd0, 7'd0));
      send_word(edit_word(4'd15, 32'hFFFF_FFFF, 7'd127));
      send_word(edit_word(FN_DEL_END, 32'd0, 7'd0));
      send_word(edit_word(FN_DEL_FRONT, 32'd0, 7'd0));

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         case (n / 100)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 59; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         send_word(edit_word(pick_func(n), pick_value(), pick_index()));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (replies_due != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** bounded_array_edit_engine_core: PASSED **");
      end else begin
         $display("** bounded_array_edit_engine_core: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
